>>> rtl/btu_pkg.sv
// Shared types, constants and the Thumb condition check for the branch target unit.
// Used by every stage of the pipeline; depends on nothing.
`default_nettype none
package btu_pkg;

   localparam logic [23:0] ARM_BX_CODE  = 24'h12FFF1;
   localparam logic [23:0] ARM_BLX_CODE = 24'h12FFF3;
   localparam logic [2:0]  ARM_B_CODE   = 3'b101;
   localparam logic [3:0]  THUMB_BCC_CODE   = 4'b1101;
   localparam logic [4:0]  THUMB_B_CODE     = 5'b11100;
   localparam logic [4:0]  THUMB_BLX_LO     = 5'b11101;
   localparam logic [4:0]  THUMB_BL_HI      = 5'b11110;
   localparam logic [4:0]  THUMB_BL_LO      = 5'b11111;
   localparam logic [7:0]  THUMB_BX_CODE    = 8'h47;

   localparam logic [3:0] COND_EQ = 4'h0;
   localparam logic [3:0] COND_NE = 4'h1;
   localparam logic [3:0] COND_CS = 4'h2;
   localparam logic [3:0] COND_CC = 4'h3;
   localparam logic [3:0] COND_MI = 4'h4;
   localparam logic [3:0] COND_PL = 4'h5;
   localparam logic [3:0] COND_VS = 4'h6;
   localparam logic [3:0] COND_VC = 4'h7;
   localparam logic [3:0] COND_HI = 4'h8;
   localparam logic [3:0] COND_LS = 4'h9;
   localparam logic [3:0] COND_GE = 4'hA;
   localparam logic [3:0] COND_LT = 4'hB;
   localparam logic [3:0] COND_GT = 4'hC;
   localparam logic [3:0] COND_LE = 4'hD;

   typedef enum logic [1:0] {
      MASK_NONE,
      MASK_BIT0,
      MASK_BITS10
   } mask_type;

   typedef struct packed {
      logic     is_branch;
      logic     taken;
      logic     link_write;
      logic     link_or1;
      logic     next_thumb;
      mask_type mask;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] tgt_a;
      logic [31:0] tgt_b;
      logic [3:0]  tgt_c;
      logic [31:0] lnk_a;
      logic [31:0] lnk_b;
      logic [3:0]  lnk_c;
   } dec_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] tgt_sum;
      logic [31:0] lnk_sum;
   } sum_type;

   function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] f);
      logic n, z, c, v, pass;
      n = f[3];
      z = f[2];
      c = f[1];
      v = f[0];
      unique case (cond)
         COND_EQ: pass = z;
         COND_NE: pass = !z;
         COND_CS: pass = c;
         COND_CC: pass = !c;
         COND_MI: pass = n;
         COND_PL: pass = !n;
         COND_VS: pass = v;
         COND_VC: pass = !v;
         COND_HI: pass = c && !z;
         COND_LS: pass = !c || z;
         COND_GE: pass = (n == v);
         COND_LT: pass = (n != v);
         COND_GT: pass = !z && (n == v);
         COND_LE: pass = z || (n != v);
         default: pass = 1'b1;
      endcase
      return pass;
   endfunction

endpackage
`default_nettype wire

>>> rtl/btu_decode.sv
// First pipeline stage: decodes the ARM or Thumb branch form and lines up adder operands.
// Depends on btu_pkg.
`default_nettype none
module btu_decode (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic            thumb_mode,
   input  wire logic [31:0]     instruction,
   input  wire logic [31:0]     instr_address,
   input  wire logic [31:0]     reg_value,
   input  wire logic [31:0]     link_value,
   input  wire logic [3:0]      cond_flags,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output btu_pkg::dec_type     out_data
);

   logic             valid_ff;
   btu_pkg::dec_type data_ff;
   btu_pkg::dec_type data_in;
   logic [15:0]      h;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign h         = instruction[15:0];

   always_comb begin
      data_in = '0;
      data_in.ctl.next_thumb = thumb_mode;
      data_in.ctl.mask       = btu_pkg::MASK_NONE;
      data_in.tgt_a = instr_address;
      data_in.lnk_a = instr_address;
      if (!thumb_mode) begin
         data_in.tgt_c = 4'd4;
         data_in.lnk_c = 4'd4;
         if (instruction[27:4] == btu_pkg::ARM_BX_CODE ||
             instruction[27:4] == btu_pkg::ARM_BLX_CODE) begin
            data_in.ctl.is_branch  = 1'b1;
            data_in.ctl.taken      = 1'b1;
            data_in.ctl.next_thumb = reg_value[0];
            data_in.ctl.mask       = btu_pkg::MASK_BIT0;
            data_in.ctl.link_write = (instruction[27:4] == btu_pkg::ARM_BLX_CODE);
            data_in.tgt_a = reg_value;
            data_in.tgt_c = 4'd0;
         end else if (instruction[27:25] == btu_pkg::ARM_B_CODE) begin
            data_in.ctl.is_branch  = 1'b1;
            data_in.ctl.taken      = 1'b1;
            data_in.ctl.link_write = instruction[24];
            data_in.tgt_b = {{6{instruction[23]}}, instruction[23:0], 2'b00};
            data_in.tgt_c = 4'd8;
         end
      end else begin
         data_in.tgt_c = 4'd2;
         // Thumb links carry the return address with the mode bit set.
         data_in.lnk_c = 4'd2;
         data_in.ctl.link_or1 = 1'b1;
         if (h[15:12] == btu_pkg::THUMB_BCC_CODE && h[11:9] != 3'b111) begin
            data_in.ctl.is_branch = 1'b1;
            if (btu_pkg::cond_pass(h[11:8], cond_flags)) begin
               data_in.ctl.taken = 1'b1;
               data_in.tgt_b = {{23{h[7]}}, h[7:0], 1'b0};
               data_in.tgt_c = 4'd4;
            end
         end else if (h[15:11] == btu_pkg::THUMB_B_CODE) begin
            data_in.ctl.is_branch = 1'b1;
            data_in.ctl.taken     = 1'b1;
            data_in.tgt_b = {{20{h[10]}}, h[10:0], 1'b0};
            data_in.tgt_c = 4'd4;
         end else if (h[15:11] == btu_pkg::THUMB_BL_HI) begin
            // The high half only stages the upper offset in the link register.
            data_in.ctl.is_branch  = 1'b1;
            data_in.ctl.link_write = 1'b1;
            data_in.ctl.link_or1   = 1'b0;
            data_in.lnk_b = {{9{h[10]}}, h[10:0], 12'h000};
            data_in.lnk_c = 4'd4;
         end else if (h[15:11] == btu_pkg::THUMB_BL_LO ||
                      h[15:11] == btu_pkg::THUMB_BLX_LO) begin
            data_in.ctl.is_branch  = 1'b1;
            data_in.ctl.taken      = 1'b1;
            data_in.ctl.link_write = 1'b1;
            if (h[15:11] == btu_pkg::THUMB_BLX_LO) begin
               data_in.ctl.next_thumb = 1'b0;
               data_in.ctl.mask       = btu_pkg::MASK_BITS10;
            end
            data_in.tgt_a = link_value;
            data_in.tgt_b = {20'h00000, h[10:0], 1'b0};
            data_in.tgt_c = 4'd0;
         end else if (h[15:8] == btu_pkg::THUMB_BX_CODE) begin
            data_in.ctl.is_branch  = 1'b1;
            data_in.ctl.taken      = 1'b1;
            data_in.ctl.link_write = h[7];
            data_in.ctl.next_thumb = reg_value[0];
            data_in.ctl.mask       = btu_pkg::MASK_BIT0;
            data_in.tgt_a = reg_value;
            data_in.tgt_c = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/btu_add.sv
// Second pipeline stage: the target and link three-operand adders.
// Depends on btu_pkg.
`default_nettype none
module btu_add (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire btu_pkg::dec_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output btu_pkg::sum_type      out_data
);

   logic             valid_ff;
   btu_pkg::sum_type data_ff;
   btu_pkg::sum_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.ctl     = in_data.ctl;
      data_in.tgt_sum = in_data.tgt_a + in_data.tgt_b + {28'h0000000, in_data.tgt_c};
      data_in.lnk_sum = in_data.lnk_a + in_data.lnk_b + {28'h0000000, in_data.lnk_c};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/btu_select.sv
// Third pipeline stage: target alignment, link value formation and the output register.
// Depends on btu_pkg.
`default_nettype none
module btu_select (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire btu_pkg::sum_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic                  is_branch,
   output logic                  taken,
   output logic [31:0]           next_pc,
   output logic                  link_write,
   output logic [31:0]           link_result,
   output logic                  next_thumb
);

   logic        valid_ff;
   logic        is_branch_ff, taken_ff, link_write_ff, next_thumb_ff;
   logic [31:0] next_pc_ff, link_result_ff;
   logic [31:0] next_pc_in, link_result_in;

   assign in_ready    = !valid_ff || out_ready;
   assign out_valid   = valid_ff;
   assign is_branch   = is_branch_ff;
   assign taken       = taken_ff;
   assign next_pc     = next_pc_ff;
   assign link_write  = link_write_ff;
   assign link_result = link_result_ff;
   assign next_thumb  = next_thumb_ff;

   always_comb begin
      unique case (in_data.ctl.mask)
         btu_pkg::MASK_BIT0:   next_pc_in = {in_data.tgt_sum[31:1], 1'b0};
         btu_pkg::MASK_BITS10: next_pc_in = {in_data.tgt_sum[31:2], 2'b00};
         default:              next_pc_in = in_data.tgt_sum;
      endcase
      if (in_data.ctl.link_write) begin
         link_result_in = {in_data.lnk_sum[31:1], in_data.lnk_sum[0] | in_data.ctl.link_or1};
      end else begin
         link_result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         is_branch_ff   <= in_data.ctl.is_branch;
         taken_ff       <= in_data.ctl.taken;
         link_write_ff  <= in_data.ctl.link_write;
         next_thumb_ff  <= in_data.ctl.next_thumb;
         next_pc_ff     <= next_pc_in;
         link_result_ff <= link_result_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/arm_thumb_branch_target_unit.sv
// ARM/Thumb branch target unit: a three-stage pipeline (decode, add, select) that takes one
// instruction per cycle while not stalled; each result leaves from the select stage's register. Every stage
// holds its item under backpressure, so the unit keeps one transfer per cycle as long as the
// result side takes one per cycle. Depends on btu_pkg, btu_decode, btu_add and btu_select.
`default_nettype none
module arm_thumb_branch_target_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_thumb_mode,
   input  wire logic [31:0] req_instruction,
   input  wire logic [31:0] req_instr_address,
   input  wire logic [31:0] req_reg_value,
   input  wire logic [31:0] req_link_value,
   input  wire logic [3:0]  req_cond_flags,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_branch,
   output logic             rsp_taken,
   output logic [31:0]      rsp_next_pc,
   output logic             rsp_link_write,
   output logic [31:0]      rsp_link_result,
   output logic             rsp_next_thumb
);

   logic             dec_valid, dec_ready;
   btu_pkg::dec_type dec_data;
   logic             sum_valid, sum_ready;
   btu_pkg::sum_type sum_data;

   btu_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .thumb_mode    (req_thumb_mode),
      .instruction   (req_instruction),
      .instr_address (req_instr_address),
      .reg_value     (req_reg_value),
      .link_value    (req_link_value),
      .cond_flags    (req_cond_flags),
      .out_valid     (dec_valid),
      .out_ready     (dec_ready),
      .out_data      (dec_data)
   );

   btu_add u_add (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   btu_select u_select (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sum_valid),
      .in_ready    (sum_ready),
      .in_data     (sum_data),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .is_branch   (rsp_is_branch),
      .taken       (rsp_taken),
      .next_pc     (rsp_next_pc),
      .link_write  (rsp_link_write),
      .link_result (rsp_link_result),
      .next_thumb  (rsp_next_thumb)
   );

endmodule
`default_nettype wire

>>> rtl/btu_checker.sv
// Port-level checks for the branch target unit, attached to the top level by bind.
// Depends only on the top level's ports.
`default_nettype none
module btu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_is_branch,
   input wire logic        rsp_taken,
   input wire logic [31:0] rsp_next_pc,
   input wire logic        rsp_link_write,
   input wire logic [31:0] rsp_link_result
);

   // A stalled result must stay valid and keep its next_pc.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc))
      else $error("result changed while stalled");

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Only a recognized branch redirects or writes the link register.
   a_non_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_branch |-> !rsp_taken && !rsp_link_write)
      else $error("non-branch redirected or linked");

   // The link value reads as zero whenever no link write is requested.
   a_link_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_link_write |-> rsp_link_result == 32'h00000000)
      else $error("link result nonzero without link write");

endmodule

bind arm_thumb_branch_target_unit btu_checker u_btu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_is_branch   (rsp_is_branch),
   .rsp_taken       (rsp_taken),
   .rsp_next_pc     (rsp_next_pc),
   .rsp_link_write  (rsp_link_write),
   .rsp_link_result (rsp_link_result)
);
`default_nettype wire
